// File: hw/rtl/fcth_pkg.sv
// ----------------------------------------------------------------------------
// fcth_pkg
// Shared types and constants of the class-by-region tally unit.
// ----------------------------------------------------------------------------
package fcth_pkg;

	localparam int CODE_W  = 16;
	localparam int COUNT_W = 32;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef enum logic {
		FUNC_TALLY = 1'b0,
		FUNC_READ  = 1'b1
	} func_t;

	typedef enum logic {
		REG_TARGET = 1'b0,
		REG_NODATA = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic signed [CODE_W-1:0] target_service;
		logic signed [CODE_W-1:0] nodata_code;
	} cfg_t;

endpackage

// File: hw/rtl/fcth_chan_if.sv
// ----------------------------------------------------------------------------
// fcth_req_if / fcth_res_if
// Valid/ready channels for requests and results of the tally unit.
// ----------------------------------------------------------------------------
interface fcth_req_if;
	import fcth_pkg::*;

	logic                     valid;
	logic                     ready;
	logic                     func;
	logic signed [CODE_W-1:0] model_code;
	logic signed [CODE_W-1:0] region_code;
	logic signed [CODE_W-1:0] service_code;

	modport source (output valid, func, model_code, region_code, service_code, input ready);
	modport sink (input valid, func, model_code, region_code, service_code, output ready);
endinterface

interface fcth_res_if;
	import fcth_pkg::*;

	logic               valid;
	logic               ready;
	logic [COUNT_W-1:0] count;
	logic               region_seen;
	logic               counted;
	logic               range_error;

	modport source (output valid, count, region_seen, counted, range_error, input ready);
	modport sink (input valid, count, region_seen, counted, range_error, output ready);
endinterface

// File: hw/rtl/fcth_ram.sv
// ----------------------------------------------------------------------------
// fcth_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fcth_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/fcth_cfg.sv
// ----------------------------------------------------------------------------
// fcth_cfg
// APB register file: target service code and no-data code.
// ----------------------------------------------------------------------------
module fcth_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [fcth_pkg::PADDR_W-1:0]  paddr,
	input  logic [fcth_pkg::PDATA_W-1:0]  pwdata,
	output logic [fcth_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	output fcth_pkg::cfg_t                cfg
);
	import fcth_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_service <= 16'sd1;
			cfg_q.nodata_code    <= -16'sd9999;
		end else if (wr_en) begin
			unique case (idx)
				REG_TARGET: cfg_q.target_service <= pwdata[CODE_W-1:0];
				REG_NODATA: cfg_q.nodata_code    <= pwdata[CODE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_TARGET: prdata = PDATA_W'(cfg_q.target_service);
			REG_NODATA: prdata = PDATA_W'(cfg_q.nodata_code);
			default:    prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// File: hw/rtl/fcth_clear.sv
// ----------------------------------------------------------------------------
// fcth_clear
// Post-reset sweep that walks every table address once.
// ----------------------------------------------------------------------------
module fcth_clear #(
	parameter int DEPTH = 12800,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	output logic          busy,
	output logic [AW-1:0] addr
);

	logic          busy_q;
	logic [AW-1:0] addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			addr_q <= '0;
		end else if (busy_q) begin
			if (addr_q == AW'(DEPTH - 1)) begin
				busy_q <= 1'b0;
			end else begin
				addr_q <= addr_q + 1'b1;
			end
		end
	end

	assign busy = busy_q;
	assign addr = addr_q;

endmodule

// File: hw/rtl/filtered_cross_tab_histogram_unit.sv
// ----------------------------------------------------------------------------
// filtered_cross_tab_histogram_unit
// Class-by-region count table with service-area and no-data filtering.
//
//   channel  dir  handshake       payload
//   req      in   valid/ready     func, model_code, region_code, service_code
//   result   out  valid/ready     count, region_seen, counted, range_error
//   apb      in   psel/penable    paddr, pwdata, prdata (pready tied high)
//
// One request per cycle sustained while the result channel is not stalled; a
// request passes through the stage 1 register and then the output register,
// from which its result is presented. The table RAM read-modify-write is the
// critical loop, closed by one-deep write forwarding.
// After reset a clear pass over the NUM_CLASSES*MAX_REGIONS addresses (12800
// by default) holds req.ready low. A stalled result holds the pipeline stage.
// ----------------------------------------------------------------------------
module filtered_cross_tab_histogram_unit #(
	parameter int NUM_CLASSES = 100,
	parameter int MAX_REGIONS = 128
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [fcth_pkg::PADDR_W-1:0] paddr,
	input  logic [fcth_pkg::PDATA_W-1:0] pwdata,
	output logic [fcth_pkg::PDATA_W-1:0] prdata,
	output logic                         pready,
	fcth_req_if.sink                     req,
	fcth_res_if.source                   result
);
	import fcth_pkg::*;

	localparam int TD = NUM_CLASSES * MAX_REGIONS;
	localparam int AW = (TD > 1) ? $clog2(TD) : 1;
	localparam int CW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int RW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;

	cfg_t cfg;

	fcth_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	logic          clr_busy;
	logic [AW-1:0] clr_addr;

	fcth_clear #(.DEPTH(TD), .AW(AW)) u_clear (
		.clk    (clk),
		.arst_n (arst_n),
		.busy   (clr_busy),
		.addr   (clr_addr)
	);

	// request decode
	logic          accept;
	logic          is_read;
	logic          cls_ok, reg_ok, in_range, filt_ok;
	logic [CW-1:0] ci0;
	logic [RW-1:0] ri0;
	logic [AW-1:0] addr0;

	assign accept  = req.valid && req.ready;
	assign is_read = (func_t'(req.func) == FUNC_READ);
	assign cls_ok  = (int'(req.model_code) >= 1) && (int'(req.model_code) <= NUM_CLASSES);
	assign reg_ok  = (int'(req.region_code) >= 1) && (int'(req.region_code) <= MAX_REGIONS);
	assign in_range = cls_ok && reg_ok;
	assign filt_ok = (req.model_code != cfg.nodata_code)
		&& (req.region_code != cfg.nodata_code)
		&& (req.service_code != cfg.nodata_code)
		&& (req.service_code == cfg.target_service);
	assign ci0   = CW'(req.model_code - 16'sd1);
	assign ri0   = RW'(req.region_code - 16'sd1);
	assign addr0 = AW'(AW'(ci0) * AW'(MAX_REGIONS)) + AW'(ri0);

	// stage 1
	logic          valid_s1, cnt_s1, rd_s1, rerr_s1;
	logic [AW-1:0] addr_s1;
	logic [RW-1:0] ri_s1;
	logic          adv;

	logic               out_v_q;
	logic [COUNT_W-1:0] out_count_q;
	logic               out_seen_q, out_counted_q, out_rerr_q;

	assign adv       = !out_v_q || result.ready;
	assign req.ready = !clr_busy && (!valid_s1 || adv);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cnt_s1  <= !is_read && filt_ok && in_range;
			rd_s1   <= is_read && in_range;
			rerr_s1 <= !in_range && (is_read || filt_ok);
			addr_s1 <= addr0;
			ri_s1   <= ri0;
		end
	end

	// memories
	logic               tab_we, seen_we;
	logic [AW-1:0]      tab_waddr;
	logic [COUNT_W-1:0] tab_wdata;
	logic [COUNT_W-1:0] tab_rdata;
	logic [RW-1:0]      seen_waddr;
	logic               seen_wdata;
	logic               seen_rdata;
	logic               wr_s1;
	logic [COUNT_W-1:0] old_cnt, new_cnt;
	logic               old_seen;

	assign wr_s1 = valid_s1 && adv && cnt_s1;

	assign tab_we     = clr_busy || wr_s1;
	assign tab_waddr  = clr_busy ? clr_addr : addr_s1;
	assign tab_wdata  = clr_busy ? '0 : new_cnt;
	assign seen_we    = clr_busy ? ({1'b0, clr_addr} < (AW+1)'(MAX_REGIONS)) : wr_s1;
	assign seen_waddr = clr_busy ? clr_addr[RW-1:0] : ri_s1;
	assign seen_wdata = !clr_busy;

	fcth_ram #(.WIDTH(COUNT_W), .DEPTH(TD), .AW(AW)) u_tab_ram (
		.clk   (clk),
		.we    (tab_we),
		.waddr (tab_waddr),
		.wdata (tab_wdata),
		.re    (accept),
		.raddr (addr0),
		.rdata (tab_rdata)
	);

	fcth_ram #(.WIDTH(1), .DEPTH(MAX_REGIONS), .AW(RW)) u_seen_ram (
		.clk   (clk),
		.we    (seen_we),
		.waddr (seen_waddr),
		.wdata (seen_wdata),
		.re    (accept),
		.raddr (ri0),
		.rdata (seen_rdata)
	);

	// forwarding of the last write-back
	logic               fwd_v_q;
	logic [AW-1:0]      fwd_addr_q;
	logic [RW-1:0]      fwd_ri_q;
	logic [COUNT_W-1:0] fwd_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_v_q <= 1'b0;
		end else if (wr_s1) begin
			fwd_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_s1) begin
			fwd_addr_q <= addr_s1;
			fwd_ri_q   <= ri_s1;
			fwd_cnt_q  <= new_cnt;
		end
	end

	assign old_cnt  = (fwd_v_q && (fwd_addr_q == addr_s1)) ? fwd_cnt_q : tab_rdata;
	assign old_seen = (fwd_v_q && (fwd_ri_q == ri_s1)) || seen_rdata;
	assign new_cnt  = (old_cnt == COUNT_MAX) ? old_cnt : old_cnt + 1'b1;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (valid_s1 && adv) begin
			out_v_q <= 1'b1;
		end else if (result.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv) begin
			out_count_q   <= cnt_s1 ? new_cnt : (rd_s1 ? old_cnt : '0);
			out_seen_q    <= cnt_s1 || (rd_s1 && old_seen);
			out_counted_q <= cnt_s1;
			out_rerr_q    <= rerr_s1;
		end
	end

	assign result.valid       = out_v_q;
	assign result.count       = out_count_q;
	assign result.region_seen = out_seen_q;
	assign result.counted     = out_counted_q;
	assign result.range_error = out_rerr_q;

endmodule

// File: tb/sv/filtered_cross_tab_histogram_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// filtered_cross_tab_histogram_unit_test
// Self-checking bench for the class-by-region tally unit. A directed table
// covers reset state, filters, range errors and back-to-back updates. Random
// requests then run under several register settings and idle patterns. Every
// result is checked against known row values or shadow counts and seen marks.
// ----------------------------------------------------------------------------
module filtered_cross_tab_histogram_unit_test;
	import fcth_pkg::*;

	localparam int NUM_CLASSES = 100;
	localparam int MAX_REGIONS = 128;
	localparam int RAND_PER_PHASE = 110;
	localparam int NUM_PHASES = 6;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic               region_seen;
		logic               counted;
		logic               range_error;
	} tally_res_t;

	typedef struct {
		func_t                    func;
		logic signed [CODE_W-1:0] model_code;
		logic signed [CODE_W-1:0] region_code;
		logic signed [CODE_W-1:0] service_code;
		bit                       known;
		tally_res_t               res;
	} cell_req_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;
	logic res_ready = 1'b0;

	fcth_req_if req_ch();
	fcth_res_if res_ch();

	assign res_ch.ready = res_ready;

	filtered_cross_tab_histogram_unit #(
		.NUM_CLASSES(NUM_CLASSES),
		.MAX_REGIONS(MAX_REGIONS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.req(req_ch),
		.result(res_ch)
	);

	always #5 clk = ~clk;

	// shadow of the block's table, seen marks and registers
	logic [COUNT_W-1:0] count_shadow [NUM_CLASSES*MAX_REGIONS];
	bit                 seen_shadow [MAX_REGIONS];
	cfg_t               cfg_shadow;

	tally_res_t expected_q[$];
	cell_req_t  cur_req;
	int         mismatches = 0;
	int         src_idle = 0;
	int         rcv_idle = 0;

	function automatic tally_res_t predict_tally(input cell_req_t r);
		tally_res_t o;
		bit         in_tbl;
		int         ri;
		int         idx;
		o = '0;
		in_tbl = r.model_code >= 1 && r.model_code <= NUM_CLASSES &&
			r.region_code >= 1 && r.region_code <= MAX_REGIONS;
		ri = int'(r.region_code) - 1;
		idx = (int'(r.model_code) - 1) * MAX_REGIONS + ri;
		if (r.func == FUNC_READ) begin
			if (in_tbl) begin
				o.count = count_shadow[idx];
				o.region_seen = seen_shadow[ri];
			end else
				o.range_error = 1'b1;
		end else if (r.model_code != cfg_shadow.nodata_code &&
			r.region_code != cfg_shadow.nodata_code &&
			r.service_code != cfg_shadow.nodata_code &&
			r.service_code == cfg_shadow.target_service) begin
			if (in_tbl) begin
				if (count_shadow[idx] != COUNT_MAX)
					count_shadow[idx] = count_shadow[idx] + 1'b1;
				seen_shadow[ri] = 1'b1;
				o.count = count_shadow[idx];
				o.region_seen = 1'b1;
				o.counted = 1'b1;
			end else
				o.range_error = 1'b1;
		end
		return o;
	endfunction

	function automatic cell_req_t row(input func_t f, input int m, input int r, input int s,
		input bit known = 1'b0, input logic [COUNT_W-1:0] c = '0, input bit sn = 1'b0,
		input bit ct = 1'b0, input bit re = 1'b0);
		cell_req_t x;
		x.func = f;
		x.model_code = CODE_W'(m);
		x.region_code = CODE_W'(r);
		x.service_code = CODE_W'(s);
		x.known = known;
		x.res = '{c, sn, ct, re};
		return x;
	endfunction

	function automatic int edge_code(input int lim);
		case ($urandom_range(4))
			0: return 0;
			1: return -1;
			2: return 32767;
			3: return -32768;
			default: return lim + 1;
		endcase
	endfunction

	function automatic cell_req_t rand_cell();
		cell_req_t r;
		int        pick;
		pick = $urandom_range(99);
		r = row(FUNC_TALLY, 0, 0, 0);
		if ($urandom_range(2) == 0) begin
			r.model_code = CODE_W'($urandom_range(3, 1));
			r.region_code = CODE_W'($urandom_range(3, 1));
		end else begin
			r.model_code = CODE_W'($urandom_range(NUM_CLASSES, 1));
			r.region_code = CODE_W'($urandom_range(MAX_REGIONS, 1));
		end
		r.service_code = cfg_shadow.target_service;
		if (pick < 55) begin
		end else if (pick < 72) begin
			r.func = FUNC_READ;
			r.service_code = CODE_W'($urandom());
		end else if (pick < 80) begin
			case ($urandom_range(3))
				0: r.service_code = CODE_W'($urandom());
				1: r.model_code = cfg_shadow.nodata_code;
				2: r.region_code = cfg_shadow.nodata_code;
				default: r.service_code = cfg_shadow.nodata_code;
			endcase
		end else if (pick < 88) begin
			r.func = func_t'($urandom_range(1));
			if ($urandom_range(1))
				r.model_code = CODE_W'(edge_code(NUM_CLASSES));
			else
				r.region_code = CODE_W'(edge_code(MAX_REGIONS));
		end else begin
			r.func = func_t'($urandom_range(1));
			r.model_code = CODE_W'($urandom());
			r.region_code = CODE_W'($urandom());
			r.service_code = CODE_W'($urandom());
		end
		return r;
	endfunction

	task automatic check_field(input string name, input logic [COUNT_W-1:0] want,
		input logic [COUNT_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	task automatic send_request(input cell_req_t r);
		if (src_idle > 0 && $urandom_range(99) < src_idle) begin
			req_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle);
		end
		req_ch.valid <= 1'b1;
		req_ch.func <= r.func;
		req_ch.model_code <= r.model_code;
		req_ch.region_code <= r.region_code;
		req_ch.service_code <= r.service_code;
		cur_req <= r;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic signed [CODE_W-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'({idx, 2'b00});
		pwdata <= PDATA_W'(val);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_TARGET)
			cfg_shadow.target_service = val;
		else
			cfg_shadow.nodata_code = val;
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (!arst_n)
			res_ready <= 1'b0;
		else
			res_ready <= (rcv_idle == 0) || ($urandom_range(99) >= rcv_idle);
	end

	always @(posedge clk) begin
		tally_res_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (expected_q.size() == 0) begin
				$error("result with no request outstanding");
				mismatches++;
			end else begin
				want = expected_q.pop_front();
				check_field("count", want.count, res_ch.count);
				check_field("region_seen", COUNT_W'(want.region_seen),
					COUNT_W'(res_ch.region_seen));
				check_field("counted", COUNT_W'(want.counted), COUNT_W'(res_ch.counted));
				check_field("range_error", COUNT_W'(want.range_error),
					COUNT_W'(res_ch.range_error));
			end
		end
		if (arst_n && req_ch.valid && req_ch.ready) begin
			want = predict_tally(cur_req);
			expected_q.push_back(cur_req.known ? cur_req.res : want);
		end
	end

	initial begin
		cell_req_t                directed[$];
		logic signed [CODE_W-1:0] ph_target [NUM_PHASES];
		logic signed [CODE_W-1:0] ph_nodata [NUM_PHASES];
		ph_target = '{16'sd1, 16'sd32767, -16'sd32768, 16'sd7, 16'sd5, 16'sd0};
		ph_nodata = '{-16'sd9999, -16'sd32768, 16'sd32767, 16'sd3, 16'sd5, 16'sd0};
		for (int i = 0; i < NUM_CLASSES*MAX_REGIONS; i++)
			count_shadow[i] = '0;
		foreach (seen_shadow[i])
			seen_shadow[i] = 1'b0;
		cfg_shadow.target_service = 16'sd1;
		cfg_shadow.nodata_code = -16'sd9999;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_ch.valid = 1'b0;
		req_ch.func = FUNC_TALLY;
		req_ch.model_code = '0;
		req_ch.region_code = '0;
		req_ch.service_code = '0;

		directed.push_back(row(FUNC_READ, 1, 1, 0, 1, 0, 0, 0, 0));
		directed.push_back(row(FUNC_READ, 100, 128, 0, 1, 0, 0, 0, 0));
		directed.push_back(row(FUNC_READ, 0, 1, 0, 1, 0, 0, 0, 1));
		directed.push_back(row(FUNC_READ, 101, 1, 0, 1, 0, 0, 0, 1));
		directed.push_back(row(FUNC_READ, 1, 129, 0, 1, 0, 0, 0, 1));
		directed.push_back(row(FUNC_READ, -32768, 32767, 0, 1, 0, 0, 0, 1));
		directed.push_back(row(FUNC_TALLY, 1, 1, 1, 1, 1, 1, 1, 0));
		directed.push_back(row(FUNC_TALLY, 1, 1, 1, 1, 2, 1, 1, 0));
		directed.push_back(row(FUNC_TALLY, 100, 128, 1, 1, 1, 1, 1, 0));
		directed.push_back(row(FUNC_TALLY, 5, 7, 2, 1));
		directed.push_back(row(FUNC_TALLY, -9999, 7, 1, 1));
		directed.push_back(row(FUNC_TALLY, 5, -9999, 1, 1));
		directed.push_back(row(FUNC_TALLY, 5, 7, -9999, 1));
		directed.push_back(row(FUNC_TALLY, -32768, -32768, -32768, 1));
		directed.push_back(row(FUNC_TALLY, 0, 5, 1, 1, 0, 0, 0, 1));
		directed.push_back(row(FUNC_TALLY, 5, 0, 1, 1, 0, 0, 0, 1));
		directed.push_back(row(FUNC_TALLY, 101, 5, 1, 1, 0, 0, 0, 1));
		directed.push_back(row(FUNC_TALLY, 5, 129, 1, 1, 0, 0, 0, 1));
		directed.push_back(row(FUNC_TALLY, 32767, -32768, 1, 1, 0, 0, 0, 1));
		directed.push_back(row(FUNC_READ, 1, 1, -32768, 1, 2, 1, 0, 0));
		directed.push_back(row(FUNC_READ, 2, 1, 32767, 1, 0, 1, 0, 0));
		directed.push_back(row(FUNC_READ, 100, 128, 0, 1, 1, 1, 0, 0));
		directed.push_back(row(FUNC_TALLY, 2, 1, 1));
		directed.push_back(row(FUNC_TALLY, 2, 1, 1));
		directed.push_back(row(FUNC_READ, 2, 1, 0));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		for (int p = 0; p < NUM_PHASES; p++) begin
			src_idle = (p / 2 == 0) ? 21 : (p / 2 == 1) ? 73 : 0;
			rcv_idle = (p / 2 == 0) ? 73 : (p / 2 == 1) ? 21 : 0;
			if (p > 0) begin
				req_ch.valid <= 1'b0;
				@(posedge clk);
				while (expected_q.size() != 0) @(posedge clk);
				repeat (3) @(posedge clk);
				if (p == NUM_PHASES - 1) begin
					ph_target[p] = CODE_W'($urandom());
					ph_nodata[p] = CODE_W'($urandom());
				end
				write_reg(REG_TARGET, ph_target[p]);
				write_reg(REG_NODATA, ph_nodata[p]);
			end else
				foreach (directed[i])
					send_request(directed[i]);
			repeat (RAND_PER_PHASE)
				send_request(rand_cell());
		end
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (expected_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("filtered_cross_tab_histogram_unit regression: pass");
		else
			$display("filtered_cross_tab_histogram_unit regression: fail");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("filtered_cross_tab_histogram_unit regression: fail");
		$finish;
	end

endmodule
